// ===== sv/gfba_pkg.sv =====
// ============================================================================
// gfba_pkg
// Types, constants and helpers shared by the grouped free-block allocator.
// ============================================================================
package gfba_pkg;

    localparam int BLK_W       = 10;
    localparam int STATUS_W    = 2;
    localparam int GROUP_SIZE  = 63;
    localparam int BLOCK_COUNT = 1024;

    // only block numbers that fit the request field can own a group entry
    localparam int STORE_BLOCKS = (BLOCK_COUNT < (1 << BLK_W)) ? BLOCK_COUNT : (1 << BLK_W);
    localparam int STORE_DEPTH  = STORE_BLOCKS * GROUP_SIZE;

    localparam int CNT_W   = $clog2(GROUP_SIZE + 1);
    localparam int SADDR_W = $clog2(GROUP_SIZE);
    localparam int GADDR_W = $clog2(STORE_DEPTH);

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SPILL,
        S_REFILL,
        S_POP_WAIT,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RES_RELEASED,
        RES_EMPTY,
        RES_REJECT,
        RES_POP
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     push;
        logic     pop;
        logic     spill_start;
        logic     refill_start;
        logic     sweep;
        logic     spill_end;
        logic     refill_end;
        logic     res_set;
        res_sel_t res_sel;
        logic     post;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic blk_ok;
        logic stack_full;
        logic head_ok;
        logic count_gt1;
        logic sweep_done;
        logic wb_busy;
        logic out_free;
    } sts_t;

    function automatic logic blk_valid(logic [BLK_W-1:0] b);
        return (b != '0) && (32'(b) < STORE_BLOCKS);
    endfunction

endpackage

// ===== sv/grouped_free_block_allocator_unit.sv =====
// ============================================================================
// grouped_free_block_allocator_unit
// Free-block allocator on a grouped free list: a working stack of free block
// numbers spilled to / refilled from a per-block group store.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid / in_ready | req_type, block_index
//  out     | output    | out_valid/out_ready | granted_block, status
//
// One request at a time; in_ready is high only while the sequencer is idle.
// A spill or a refill copies GROUP_SIZE entries through one memory port, one
// entry a cycle; after a refill the allocate is decoded once more and pops.
// Reset sets the stack to the empty chain head; the group store is not
// cleared. A stalled result waits in the output register; the next request
// is taken once the result has moved into it.
module grouped_free_block_allocator_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [gfba_pkg::BLK_W-1:0]    block_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gfba_pkg::BLK_W-1:0]    granted_block,
    output logic [gfba_pkg::STATUS_W-1:0] status
);
    import gfba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gfba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gfba_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .block_index   (block_index),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .granted_block (granted_block),
        .status        (status)
    );

endmodule

// ===== sv/gfba_ctrl.sv =====
// ============================================================================
// gfba_ctrl
// Request sequencer: decodes each request and steps the datapath through
// push, pop, group spill and group refill.
// ============================================================================
module gfba_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gfba_pkg::sts_t sts,
    output gfba_pkg::cmd_t cmd
);
    import gfba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (sts.is_release)
                begin
                    if (sts.blk_ok && sts.stack_full)
                        state_next = S_SPILL;
                    else
                        state_next = S_RESP;
                end
                else if (sts.count_gt1)
                begin
                    state_next = S_POP_WAIT;
                end
                else if (sts.head_ok)
                begin
                    state_next = S_REFILL;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SPILL:
            begin
                if (sts.sweep_done && !sts.wb_busy)
                    state_next = S_RESP;
            end
            S_REFILL:
            begin
                // stack is full again: decode the allocate once more to pop
                if (sts.sweep_done && !sts.wb_busy)
                    state_next = S_DECODE;
            end
            S_POP_WAIT:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECODE:
            begin
                if (sts.is_release)
                begin
                    if (!sts.blk_ok)
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_REJECT;
                    end
                    else if (sts.stack_full)
                    begin
                        cmd.spill_start = 1'b1;
                    end
                    else
                    begin
                        cmd.push    = 1'b1;
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_RELEASED;
                    end
                end
                else if (sts.count_gt1)
                begin
                    cmd.pop = 1'b1;
                end
                else if (sts.head_ok)
                begin
                    cmd.refill_start = 1'b1;
                end
                else
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_EMPTY;
                end
            end
            S_SPILL:
            begin
                if (!sts.sweep_done)
                begin
                    cmd.sweep = 1'b1;
                end
                else if (!sts.wb_busy)
                begin
                    cmd.spill_end = 1'b1;
                    cmd.res_set   = 1'b1;
                    cmd.res_sel   = RES_RELEASED;
                end
            end
            S_REFILL:
            begin
                if (!sts.sweep_done)
                    cmd.sweep = 1'b1;
                else if (!sts.wb_busy)
                    cmd.refill_end = 1'b1;
            end
            S_POP_WAIT:
            begin
                cmd.res_set = 1'b1;
                cmd.res_sel = RES_POP;
            end
            S_RESP:
            begin
                cmd.post = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/gfba_datapath.sv =====
// ============================================================================
// gfba_datapath
// Free stack, group store, stack count, chain head, copy sweep and the
// result register.
// ============================================================================
module gfba_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gfba_pkg::cmd_t                cmd,
    output gfba_pkg::sts_t                sts,
    input  logic                          req_type,
    input  logic [gfba_pkg::BLK_W-1:0]    block_index,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [gfba_pkg::BLK_W-1:0]    granted_block,
    output logic [gfba_pkg::STATUS_W-1:0] status
);
    import gfba_pkg::*;

    localparam logic [GADDR_W-1:0] GROUP_SIZE_A = GADDR_W'(GROUP_SIZE);
    localparam logic [CNT_W-1:0]   GROUP_SIZE_C = CNT_W'(GROUP_SIZE);
    localparam logic [CNT_W-1:0]   LAST_IDX     = CNT_W'(GROUP_SIZE - 1);

    // entry 0 of the stack lives in head_reg; the memory's entry 0 is unused
    logic [BLK_W-1:0] stack_mem [GROUP_SIZE];
    logic [BLK_W-1:0] group_mem [STORE_DEPTH];

    logic                req_type_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [BLK_W-1:0]    head_reg,   head_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [GADDR_W-1:0]  gaddr_reg,  gaddr_next;
    logic                spill_mode_reg, spill_mode_next;
    logic                wb_valid_reg, wb_valid_next;
    logic [CNT_W-1:0]    wb_idx_reg, wb_idx_next;
    logic [BLK_W-1:0]    pend_block_reg, pend_block_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [BLK_W-1:0]    out_block_reg, out_block_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [BLK_W-1:0]    stack_rd_reg;
    logic [BLK_W-1:0]    group_rd_reg;

    logic                stack_we;
    logic [SADDR_W-1:0]  stack_waddr;
    logic [BLK_W-1:0]    stack_wdata;
    logic [SADDR_W-1:0]  stack_raddr;
    logic                group_we;
    logic [BLK_W-1:0]    group_wdata;
    logic [BLK_W-1:0]    base_blk;
    logic [GADDR_W-1:0]  base_addr;

    always_comb
    begin
        sts.is_release = (req_type_reg == REQ_RELEASE);
        sts.blk_ok     = blk_valid(blk_reg);
        sts.stack_full = (count_reg >= LAST_IDX);
        sts.head_ok    = blk_valid(head_reg);
        sts.count_gt1  = (count_reg > CNT_W'(1));
        sts.sweep_done = (idx_reg == GROUP_SIZE_C);
        sts.wb_busy    = wb_valid_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign base_blk  = cmd.spill_start ? blk_reg : head_reg;
    assign base_addr = GADDR_W'(base_blk) * GROUP_SIZE_A;

    always_comb
    begin
        count_next       = count_reg;
        head_next        = head_reg;
        idx_next         = idx_reg;
        gaddr_next       = gaddr_reg;
        spill_mode_next  = spill_mode_reg;
        wb_valid_next    = 1'b0;
        wb_idx_next      = wb_idx_reg;
        pend_block_next  = pend_block_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_block_next   = out_block_reg;
        out_status_next  = out_status_reg;
        stack_we         = 1'b0;
        stack_waddr      = count_reg[SADDR_W-1:0];
        stack_wdata      = blk_reg;
        stack_raddr      = idx_reg[SADDR_W-1:0];
        group_we         = 1'b0;
        group_wdata      = stack_rd_reg;

        if (cmd.push)
        begin
            stack_we   = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.pop)
        begin
            count_next  = count_reg - CNT_W'(1);
            stack_raddr = SADDR_W'(count_reg - CNT_W'(1));
        end

        if (cmd.spill_start || cmd.refill_start)
        begin
            idx_next        = '0;
            gaddr_next      = base_addr;
            spill_mode_next = cmd.spill_start;
        end

        // read side of the copy; the write lands in the next cycle
        if (cmd.sweep)
        begin
            wb_valid_next = 1'b1;
            wb_idx_next   = idx_reg;
            idx_next      = idx_reg + CNT_W'(1);
            if (!spill_mode_reg)
                gaddr_next = gaddr_reg + GADDR_W'(1);
        end

        if (wb_valid_reg)
        begin
            if (spill_mode_reg)
            begin
                group_we   = 1'b1;
                gaddr_next = gaddr_reg + GADDR_W'(1);
                // the released block fills the last slot only when it was
                // not already full before the request
                if (wb_idx_reg == '0)
                    group_wdata = head_reg;
                else if (wb_idx_reg == LAST_IDX && count_reg == LAST_IDX)
                    group_wdata = blk_reg;
                else
                    group_wdata = stack_rd_reg;
            end
            else if (wb_idx_reg == '0)
            begin
                head_next = group_rd_reg;
            end
            else
            begin
                stack_we    = 1'b1;
                stack_waddr = wb_idx_reg[SADDR_W-1:0];
                stack_wdata = group_rd_reg;
            end
        end

        if (cmd.spill_end)
        begin
            head_next  = blk_reg;
            count_next = CNT_W'(1);
        end

        if (cmd.refill_end)
            count_next = GROUP_SIZE_C;

        if (cmd.res_set)
        begin
            case (cmd.res_sel)
                RES_RELEASED:
                begin
                    pend_block_next  = '0;
                    pend_status_next = ST_OK;
                end
                RES_EMPTY:
                begin
                    pend_block_next  = '0;
                    pend_status_next = ST_EMPTY;
                end
                RES_REJECT:
                begin
                    pend_block_next  = '0;
                    pend_status_next = ST_REJECT;
                end
                default:
                begin
                    // a popped zero is reported as no free block
                    pend_block_next  = stack_rd_reg;
                    pend_status_next = (stack_rd_reg != '0) ? ST_OK : ST_EMPTY;
                end
            endcase
        end

        if (cmd.post)
        begin
            out_valid_next  = 1'b1;
            out_block_next  = pend_block_reg;
            out_status_next = pend_status_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= CNT_W'(1);
            head_reg       <= '0;
            idx_reg        <= '0;
            spill_mode_reg <= 1'b0;
            wb_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            head_reg       <= head_next;
            idx_reg        <= idx_next;
            spill_mode_reg <= spill_mode_next;
            wb_valid_reg   <= wb_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_type;
            blk_reg      <= block_index;
        end
        gaddr_reg       <= gaddr_next;
        wb_idx_reg      <= wb_idx_next;
        pend_block_reg  <= pend_block_next;
        pend_status_reg <= pend_status_next;
        out_block_reg   <= out_block_next;
        out_status_reg  <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (group_we)
            group_mem[gaddr_reg] <= group_wdata;
        group_rd_reg <= group_mem[gaddr_reg];
    end

    assign out_valid     = out_valid_reg;
    assign granted_block = out_block_reg;
    assign status        = out_status_reg;

endmodule

// ===== test/tb_grouped_free_block_allocator_unit.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_grouped_free_block_allocator_unit
// Self-checking bench for the grouped free-block allocator. Directed table
// requests precede random bursts leaning to release, allocate or neither,
// so the stack spills into the group store and refills from the chain.
// Results are checked in order against typed rows or a free-list predictor.
// ============================================================================
module tb_grouped_free_block_allocator_unit;

    import gfba_pkg::*;

    localparam int TOTAL_REQS   = 1620;
    localparam int CALM_REQS    = 200;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_ROWS     = 20;

    typedef struct packed {
        logic [BLK_W-1:0]    blk;
        logic [STATUS_W-1:0] st;
    } grant_t;

    typedef struct packed {
        logic                rt;
        logic [BLK_W-1:0]    bi;
        logic                typed;
        logic [BLK_W-1:0]    blk;
        logic [STATUS_W-1:0] st;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                req_type;
    logic [BLK_W-1:0]    block_index;
    logic                out_valid;
    logic                out_ready;
    logic [BLK_W-1:0]    granted_block;
    logic [STATUS_W-1:0] status;

    // free-list shadow
    int unsigned      stk_depth;
    logic [BLK_W-1:0] stk [GROUP_SIZE];
    logic [BLK_W-1:0] grp_mem [STORE_BLOCKS][GROUP_SIZE];

    grant_t      pending_grants [$];
    int unsigned req_cnt;
    int unsigned err_cnt;
    int unsigned cycle_cnt;
    bit          calm;

    // typed rows follow LIFO order from an empty list
    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{REQ_ALLOC,   10'd0,    1'b1, 10'd0,    ST_EMPTY},
        '{REQ_RELEASE, 10'd0,    1'b1, 10'd0,    ST_REJECT},
        '{REQ_RELEASE, 10'd1023, 1'b1, 10'd0,    ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b1, 10'd1023, ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b1, 10'd0,    ST_EMPTY},
        '{REQ_RELEASE, 10'd1,    1'b1, 10'd0,    ST_OK},
        '{REQ_RELEASE, 10'h155,  1'b1, 10'd0,    ST_OK},
        '{REQ_RELEASE, 10'h2AA,  1'b1, 10'd0,    ST_OK},
        '{REQ_RELEASE, 10'd512,  1'b1, 10'd0,    ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b1, 10'd512,  ST_OK},
        '{REQ_RELEASE, 10'd7,    1'b1, 10'd0,    ST_OK},
        '{REQ_RELEASE, 10'd7,    1'b1, 10'd0,    ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK},
        '{REQ_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK},
        '{REQ_RELEASE, 10'd0,    1'b1, 10'd0,    ST_REJECT},
        '{REQ_ALLOC,   10'd1023, 1'b0, 10'd0,    ST_OK},
        '{REQ_RELEASE, 10'd1023, 1'b1, 10'd0,    ST_OK}
    };

    grouped_free_block_allocator_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_block (granted_block),
        .status        (status)
    );

    always #4 clk = ~clk;

    function automatic bit blk_ok(input logic [BLK_W-1:0] b);
        return (b != '0) && (int'(b) < BLOCK_COUNT) && (int'(b) < STORE_BLOCKS);
    endfunction

    function automatic void predict_grant(input logic rt, input logic [BLK_W-1:0] bi,
                                          output grant_t res);
        logic [BLK_W-1:0] head;
        logic [BLK_W-1:0] got;
        res = '{blk: '0, st: ST_EMPTY};
        if (rt == REQ_RELEASE)
        begin
            if (!blk_ok(bi))
            begin
                res.st = ST_REJECT;
                return;
            end
            if (stk_depth < GROUP_SIZE)
            begin
                stk[stk_depth] = bi;
                stk_depth++;
            end
            // full stack spills into the released block's group entry
            if (stk_depth >= GROUP_SIZE)
            begin
                for (int i = 0; i < GROUP_SIZE; i++)
                    grp_mem[bi][i] = stk[i];
                stk[0]    = bi;
                stk_depth = 1;
            end
            res.st = ST_OK;
            return;
        end
        head = stk[0];
        if (stk_depth <= 1 && blk_ok(head))
        begin
            for (int i = 0; i < GROUP_SIZE; i++)
                stk[i] = grp_mem[head][i];
            stk_depth = GROUP_SIZE;
            if (int'(stk[0]) >= BLOCK_COUNT)
                stk_depth = 0;
        end
        if (stk_depth > 1 && stk_depth <= GROUP_SIZE)
        begin
            stk_depth--;
            got = stk[stk_depth];
            if (got != '0)
            begin
                res.blk = got;
                res.st  = ST_OK;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 30)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic send_req(input logic rt, input logic [BLK_W-1:0] bi, input logic typed,
                            input grant_t want);
        int unsigned gap;
        grant_t      model;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rt;
        block_index <= bi;
        do
            @(posedge clk);
        while (!in_ready);
        predict_grant(rt, bi, model);
        pending_grants.push_back(typed ? want : model);
        req_cnt++;
    endtask

    // request side
    initial
    begin
        grant_t           want;
        logic             rt;
        logic [BLK_W-1:0] bi;
        int unsigned      burst;
        int unsigned      rel_pct;
        int unsigned      pick;
        in_valid    <= 1'b0;
        req_type    <= REQ_ALLOC;
        block_index <= '0;
        rst_n       <= 1'b0;
        req_cnt   = 0;
        err_cnt   = 0;
        calm      = 1'b0;
        stk_depth = 1;
        foreach (stk[i])
            stk[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
        begin
            want.blk = dir_tbl[i].blk;
            want.st  = dir_tbl[i].st;
            send_req(dir_tbl[i].rt, dir_tbl[i].bi, dir_tbl[i].typed, want);
        end

        // bursts lean toward release (spills), allocate (refills) or neither
        while (req_cnt < TOTAL_REQS)
        begin
            case ($urandom_range(0, 2))
                0:       rel_pct = 90;
                1:       rel_pct = 10;
                default: rel_pct = 50;
            endcase
            burst = $urandom_range(20, 140);
            for (int k = 0; k < burst && req_cnt < TOTAL_REQS; k++)
            begin
                calm = (req_cnt >= TOTAL_REQS - CALM_REQS);
                rt   = ($urandom_range(1, 100) <= rel_pct) ? REQ_RELEASE : REQ_ALLOC;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    bi = '0;
                else if (pick == 1)
                    bi = BLK_W'(BLOCK_COUNT - 1);
                else
                    bi = BLK_W'($urandom_range(1, BLOCK_COUNT - 1));
                send_req(rt, bi, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && pending_grants.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off to back up the block
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && req_cnt >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        grant_t exp_g;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_grants.size() == 0)
                report_mismatch($sformatf("unexpected result block=%0d status=%0d",
                                          granted_block, status));
            else
            begin
                exp_g = pending_grants.pop_front();
                if (granted_block !== exp_g.blk)
                    report_mismatch($sformatf("granted_block %0d, expected %0d",
                                              granted_block, exp_g.blk));
                if (status !== exp_g.st)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, exp_g.st));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_grants.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial cycle_cnt = 0;

endmodule
